// ----- src/hxd_pkg.sv -----
// Shared types, character codes and helper functions for the hex escape decoder.
package hxd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BSL,
        PH_X,
        PH_HI
    } phase_t;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END_OK  = 2'd1;
    localparam logic [1:0] KIND_END_OVF = 2'd2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;

    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = 3;

    localparam int            ADDR_W           = 3;
    localparam logic [0:0]    REG_IDX_CAPACITY = 1'b0;
    localparam logic [15:0]   CAPACITY_RESET   = 16'd256;

    typedef struct packed {
        logic [RES_CNT_W-1:0]             count;
        logic [MAX_RESULTS-1:0][7:0]      bytes;
        logic [MAX_RESULTS-1:0][1:0]      kinds;
    } res_bundle_t;

    typedef struct packed {
        phase_t phase;
        logic   overflow;
    } dec_status_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Letters a-f and A-F have the digit's value minus nine in their low nibble.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39)
        begin
            v = c[3:0];
        end
        else
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ----- src/hxd_apb_regs.sv -----
// APB register file holding the output capacity.
module hxd_apb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hxd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [15:0]                capacity
);

    logic [15:0] capacity_reg;
    logic        wr_en;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready &&
                      (paddr[2] == hxd_pkg::REG_IDX_CAPACITY);
    assign capacity = capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= hxd_pkg::CAPACITY_RESET;
        end
        else if (wr_en)
        begin
            capacity_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == hxd_pkg::REG_IDX_CAPACITY)
        begin
            prdata = {16'd0, capacity_reg};
        end
    end

endmodule

// ----- src/hxd_decoder.sv -----
// Escape state machine: turns one buffered item into a bundle of up to four results.
module hxd_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           item_byte,
    input  logic                 item_end,
    input  logic                 advance,
    input  logic [15:0]          capacity,
    output hxd_pkg::res_bundle_t bundle,
    output hxd_pkg::dec_status_t status
);

    localparam int EW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 3;

    hxd_pkg::phase_t         phase_reg, phase_next;
    logic [7:0]              held_reg, held_next;
    logic [COUNT_BITS-1:0]   bw_reg, bw_next;
    logic                    ovf_reg, ovf_next;

    logic [3:0][7:0]                 cand;
    logic [hxd_pkg::RES_CNT_W-1:0]   m;
    logic [hxd_pkg::RES_CNT_W-1:0]   s;
    logic [3:0]                      ok;
    logic                            rescan;
    logic                            hit;
    logic [EW-1:0]                   bwe;
    logic [EW-1:0]                   cmax_e;

    assign cmax_e = {{(EW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hxd_pkg::PH_IDLE;
            held_reg  <= '0;
            bw_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            bw_reg    <= bw_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        cand       = '0;
        m          = '0;
        rescan     = 1'b0;
        phase_next = phase_reg;
        held_next  = held_reg;

        if (item_end)
        begin
            // Flush whatever part of an escape is still held.
            unique case (phase_reg)
                hxd_pkg::PH_IDLE:
                begin
                    m = 3'd0;
                end
                hxd_pkg::PH_BSL:
                begin
                    cand[0] = hxd_pkg::CH_BACKSLASH;
                    m       = 3'd1;
                end
                hxd_pkg::PH_X:
                begin
                    cand[0] = hxd_pkg::CH_BACKSLASH;
                    cand[1] = hxd_pkg::CH_X;
                    m       = 3'd2;
                end
                hxd_pkg::PH_HI:
                begin
                    cand[0] = hxd_pkg::CH_BACKSLASH;
                    cand[1] = hxd_pkg::CH_X;
                    cand[2] = held_reg;
                    m       = 3'd3;
                end
                default:
                begin
                    m = 3'd0;
                end
            endcase
        end
        else if (!ovf_reg)
        begin
            unique case (phase_reg)
                hxd_pkg::PH_IDLE:
                begin
                    rescan = 1'b1;
                end
                hxd_pkg::PH_BSL:
                begin
                    if (item_byte == hxd_pkg::CH_X)
                    begin
                        phase_next = hxd_pkg::PH_X;
                    end
                    else
                    begin
                        cand[0] = hxd_pkg::CH_BACKSLASH;
                        m       = 3'd1;
                        rescan  = 1'b1;
                    end
                end
                hxd_pkg::PH_X:
                begin
                    if (hxd_pkg::is_hex(item_byte))
                    begin
                        held_next  = item_byte;
                        phase_next = hxd_pkg::PH_HI;
                    end
                    else
                    begin
                        cand[0] = hxd_pkg::CH_BACKSLASH;
                        cand[1] = hxd_pkg::CH_X;
                        m       = 3'd2;
                        rescan  = 1'b1;
                    end
                end
                hxd_pkg::PH_HI:
                begin
                    if (hxd_pkg::is_hex(item_byte))
                    begin
                        cand[0]    = {hxd_pkg::hex_val(held_reg), hxd_pkg::hex_val(item_byte)};
                        m          = 3'd1;
                        phase_next = hxd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        cand[0] = hxd_pkg::CH_BACKSLASH;
                        cand[1] = hxd_pkg::CH_X;
                        cand[2] = held_reg;
                        m       = 3'd3;
                        rescan  = 1'b1;
                    end
                end
                default:
                begin
                    m = 3'd0;
                end
            endcase

            // The byte that ended a failed escape is handled again from idle.
            if (rescan)
            begin
                if (item_byte == hxd_pkg::CH_BACKSLASH)
                begin
                    phase_next = hxd_pkg::PH_BSL;
                end
                else
                begin
                    phase_next    = hxd_pkg::PH_IDLE;
                    cand[m[1:0]]  = item_byte;
                    m             = m + 3'd1;
                end
            end
        end

        // Emits succeed as a prefix: once one hits the capacity, all later ones fail.
        s   = '0;
        bwe = '0;
        for (int k = 0; k < hxd_pkg::MAX_RESULTS; k++)
        begin
            bwe   = EW'(bw_reg) + EW'(k);
            ok[k] = !ovf_reg && (3'(k) < m) &&
                    ((bwe + EW'(1)) < EW'(capacity)) && (bwe < cmax_e);
            s     = s + 3'(ok[k]);
        end
        hit = (s < m);

        bundle.bytes = cand;
        bundle.kinds = '0;
        for (int k = 0; k < hxd_pkg::MAX_RESULTS; k++)
        begin
            bundle.kinds[k] = hxd_pkg::KIND_DATA;
        end

        if (item_end)
        begin
            bundle.bytes[s[1:0]] = 8'd0;
            bundle.kinds[s[1:0]] = (ovf_reg || hit || (capacity == 16'd0)) ?
                                   hxd_pkg::KIND_END_OVF : hxd_pkg::KIND_END_OK;
            bundle.count = s + 3'd1;
            phase_next   = hxd_pkg::PH_IDLE;
            held_next    = '0;
            bw_next      = '0;
            ovf_next     = 1'b0;
        end
        else
        begin
            bundle.count = s;
            bw_next      = bw_reg + COUNT_BITS'(s);
            ovf_next     = ovf_reg || hit;
            if (hit)
            begin
                phase_next = hxd_pkg::PH_IDLE;
                held_next  = '0;
            end
        end
    end

    assign status.phase    = phase_reg;
    assign status.overflow = ovf_reg;

endmodule

// ----- src/hxd_result_buf.sv -----
// Output register that hands out the results of one item, one transfer per cycle while m_axis_tready is high.
module hxd_result_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  hxd_pkg::res_bundle_t bundle,
    output logic                 can_load,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast,
    output logic [hxd_pkg::RES_CNT_W-1:0] count
);

    logic [hxd_pkg::RES_CNT_W-1:0]          cnt_reg, cnt_next;
    logic [hxd_pkg::MAX_RESULTS-1:0][7:0]   bytes_reg, bytes_next;
    logic [hxd_pkg::MAX_RESULTS-1:0][1:0]   kinds_reg, kinds_next;
    logic                                   xfer;

    assign xfer          = m_axis_tvalid && m_axis_tready;
    assign can_load      = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_axis_tready);
    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata  = bytes_reg[0];
    assign m_axis_tuser  = kinds_reg[0];
    assign m_axis_tlast  = (cnt_reg == 3'd1);
    assign count         = cnt_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        kinds_next = kinds_reg;
        if (load)
        begin
            cnt_next   = bundle.count;
            bytes_next = bundle.bytes;
            kinds_next = bundle.kinds;
        end
        else if (xfer)
        begin
            cnt_next = cnt_reg - 3'd1;
            for (int k = 0; k < hxd_pkg::MAX_RESULTS - 1; k++)
            begin
                bytes_next[k] = bytes_reg[k+1];
                kinds_next[k] = kinds_reg[k+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        kinds_reg <= kinds_next;
    end

endmodule

// ----- src/hex_escape_decoder_top.sv -----
// Top level of the backslash-x hex escape decoder.
//
//  Channel   | Direction | Handshake           | Payload
//  ----------+-----------+---------------------+-------------------------------------------
//  s_axis    | in        | tvalid / tready     | tdata[7:0] in_byte, tlast end_of_text
//  m_axis    | out       | tvalid / tready     | tdata[7:0] out_byte, tuser[1:0] result_kind,
//            |           |                     | tlast last_of_run
//  apb       | in        | psel/penable/pready | 0x0 out_capacity (16 bits)
//
// An input transfer lands in an input register; the escape logic then decodes it in one pass
// into an output register that holds all of that item's results.
// Items of zero or one result are taken at one byte per cycle while m_axis_tready is high.
// A failed escape or a flushing end gives up to four results; while they are handed out,
// the next item with results waits until only the last one is left in the output register.
// Reset clears the escape state and the byte count and sets the capacity to 256.
// A stalled output holds its result while one more item waits in the input register.
module hex_escape_decoder_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] in_byte
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]                 m_axis_tuser,   // [1:0] result_kind
    output logic                       m_axis_tlast,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hxd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic                          item_valid_reg, item_valid_next;
    logic [7:0]                    item_byte_reg;
    logic                          item_end_reg;
    logic                          s_xfer;
    logic                          consume;
    logic                          can_load;
    logic [15:0]                   capacity;
    logic [hxd_pkg::RES_CNT_W-1:0] buf_count;
    hxd_pkg::res_bundle_t          bundle;
    hxd_pkg::dec_status_t          status;

    hxd_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    hxd_decoder #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_byte (item_byte_reg),
        .item_end  (item_end_reg),
        .advance   (consume),
        .capacity  (capacity),
        .bundle    (bundle),
        .status    (status)
    );

    hxd_result_buf u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (consume && (bundle.count != 3'd0)),
        .bundle        (bundle),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .count         (buf_count)
    );

    // An item with no results never waits for the output register.
    assign consume       = item_valid_reg && ((bundle.count == 3'd0) || can_load);
    assign s_axis_tready = !item_valid_reg || consume;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (s_xfer)
        begin
            item_valid_next = 1'b1;
        end
        else if (consume)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            item_byte_reg <= s_axis_tdata;
            item_end_reg  <= s_axis_tlast;
        end
    end

    // A status result always closes the results of its item.
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != hxd_pkg::KIND_DATA)) |-> m_axis_tlast)
        else $error("status result without tlast");

    // After an overflow nothing of an escape may stay held.
    a_ovf_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status.overflow |-> (status.phase == hxd_pkg::PH_IDLE))
        else $error("escape held after overflow");

    // A waiting item is neither lost nor overwritten.
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !consume) |=> (item_valid_reg && $stable(item_byte_reg)))
        else $error("input register lost its item");

    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buf_count <= 3'(hxd_pkg::MAX_RESULTS))
        else $error("output register holds too many results");

endmodule
